>>> rtl/tts_pkg.sv
`default_nettype none
package tts_pkg;

  localparam int ROW_COUNT  = 24;
  localparam int COL_COUNT  = 40;
  localparam int CELL_COUNT = ROW_COUNT * COL_COUNT;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  // field widths of the channels
  localparam int ROW_W  = 5;
  localparam int COL_W  = 6;
  localparam int CHAR_W = 7;

  localparam logic [CHAR_W-1:0] CH_RUBOUT = 7'h5F;
  localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
  localparam logic [CHAR_W-1:0] CH_DEL    = 7'h7F;
  localparam logic [CHAR_W-1:0] CH_CURSOR = 7'h5F;

  localparam logic [1:0] BLINK_MOD  = 2'd3;
  localparam logic [1:0] BLINK_SHOW = 2'd2;

  localparam logic [1:0] MODE_PUT   = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_CURS,
    ST_RDW,
    ST_DONE
  } tts_state_t;

endpackage
`default_nettype wire

>>> rtl/tts_if.sv
`default_nettype none
interface tts_in_if import tts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       mode;
  logic [7:0]       data_byte;
  logic [ROW_W-1:0] read_row;
  logic [COL_W-1:0] read_col;

  modport source (output valid, mode, data_byte, read_row, read_col, input ready);
  modport sink   (input valid, mode, data_byte, read_row, read_col, output ready);
endinterface

interface tts_out_if import tts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] cell_char;
  logic [ROW_W-1:0]  cursor_row;
  logic [COL_W-1:0]  cursor_col;
  logic              scrolled;

  modport source (output valid, cell_char, cursor_row, cursor_col, scrolled, input ready);
  modport sink   (input valid, cell_char, cursor_row, cursor_col, scrolled, output ready);
endinterface
`default_nettype wire

>>> rtl/text_terminal_screen.sv
`default_nettype none
// Character terminal of ROW_COUNT x COL_COUNT cells held in one single-port RAM, rows kept as a
// ring under a top-row offset. After reset the block sweeps the RAM to spaces, one cell a
// cycle (CELL_COUNT = 960 cells), and takes no beat until that is done. Each beat then gives
// one result: a read passes EXEC, RDW and DONE, a byte EXEC, CURS and DONE, a blink tick
// EXEC and DONE, and a byte that scrolls the screen adds the SCROLL sweep, which clears the new
// bottom row through the RAM port. A new beat is taken while the previous result still waits.
module text_terminal_screen import tts_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  tts_in_if.sink   in_ch,
  tts_out_if.source out_ch
);

  tts_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [COL_W-1:0]  sweep_r;
  logic [1:0]        mode_r;
  logic [CHAR_W-1:0] byte_r;
  logic [ROW_W-1:0]  rrow_r;
  logic [COL_W-1:0]  rcol_r;
  logic [ROW_W-1:0]  cur_row_r;
  logic [COL_W-1:0]  cur_col_r;
  logic [ROW_W-1:0]  top_r;
  logic [1:0]        blink_r;
  logic              scroll_r;
  logic [CHAR_W-1:0] cell_r;

  logic              out_valid_r;
  logic [CHAR_W-1:0] out_cell_r;
  logic [ROW_W-1:0]  out_row_r;
  logic [COL_W-1:0]  out_col_r;
  logic              out_scroll_r;

  // byte handling
  logic              is_rub, is_cr, is_prt;
  logic [ROW_W:0]    row_t;
  logic [COL_W-1:0]  col_nxt;
  logic [ROW_W-1:0]  row_nxt;
  logic              put_scroll;
  logic [ROW_W-1:0]  top_nxt;
  logic [1:0]        blink_nxt;
  logic              rd_ok;

  // RAM addressing
  logic [ROW_W-1:0]  a_row;
  logic [COL_W-1:0]  a_col;
  logic [ROW_W:0]    ring_sum;
  logic [ROW_W-1:0]  ring_row;
  logic [ADDR_W-1:0] cell_addr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [CHAR_W-1:0] ram_rdata;

  logic in_acc, out_load;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    is_rub = (byte_r == CH_RUBOUT);
    is_cr  = (byte_r == CH_CR);
    // rubout sits inside the printable range but is not printed
    is_prt = !is_rub && (byte_r >= CH_SPACE) && (byte_r < CH_DEL);
    row_t   = {1'b0, cur_row_r};
    col_nxt = cur_col_r;
    if (is_rub) begin
      if (cur_col_r != '0) begin
        col_nxt = cur_col_r - 1'b1;
      end else if (cur_row_r != '0) begin
        row_t   = {1'b0, cur_row_r} - 1'b1;
        col_nxt = COL_W'(COL_COUNT - 1);
      end
    end else if (is_cr) begin
      col_nxt = '0;
      row_t   = {1'b0, cur_row_r} + 1'b1;
    end else if (is_prt) begin
      if (cur_col_r == COL_W'(COL_COUNT - 1)) begin
        col_nxt = '0;
        row_t   = {1'b0, cur_row_r} + 1'b1;
      end else begin
        col_nxt = cur_col_r + 1'b1;
      end
    end
    put_scroll = (row_t == (ROW_W + 1)'(ROW_COUNT));
    row_nxt    = put_scroll ? ROW_W'(ROW_COUNT - 1) : row_t[ROW_W-1:0];
    top_nxt    = (top_r == ROW_W'(ROW_COUNT - 1)) ? '0 : top_r + 1'b1;
    blink_nxt  = (blink_r == BLINK_MOD - 2'd1) ? 2'd0 : blink_r + 2'd1;
    rd_ok      = (rrow_r < ROW_W'(ROW_COUNT)) && (rcol_r < COL_W'(COL_COUNT));
  end

  // screen row to ring row, then cell address
  always_comb begin
    ring_sum  = {1'b0, a_row} + {1'b0, top_r};
    ring_row  = (ring_sum >= (ROW_W + 1)'(ROW_COUNT)) ?
                ROW_W'(ring_sum - (ROW_W + 1)'(ROW_COUNT)) : ring_sum[ROW_W-1:0];
    cell_addr = ADDR_W'(ring_row) * ADDR_W'(COL_COUNT) + ADDR_W'(a_col);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR:  if (clr_cnt_r == ADDR_W'(CELL_COUNT - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc) state_nxt = ST_EXEC;
      ST_EXEC: begin
        case (mode_r)
          MODE_PUT:  state_nxt = put_scroll ? ST_SCROLL : ST_CURS;
          MODE_READ: state_nxt = ST_RDW;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_SCROLL: if (sweep_r == COL_W'(COL_COUNT - 1)) state_nxt = ST_CURS;
      ST_CURS:   state_nxt = ST_DONE;
      ST_RDW:    state_nxt = ST_DONE;
      ST_DONE:   if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ch.ready = 1'b0;
    ram_we      = 1'b0;
    ram_wdata   = CH_SPACE;
    a_row       = cur_row_r;
    a_col       = cur_col_r;
    ram_addr    = cell_addr;
    case (state_r)
      ST_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_cnt_r;
      end
      ST_IDLE: in_ch.ready = 1'b1;
      ST_EXEC: begin
        case (mode_r)
          MODE_PUT: begin
            ram_we    = is_rub || is_cr || is_prt;
            ram_wdata = is_prt ? byte_r : CH_SPACE;
          end
          MODE_READ: begin
            a_row = rrow_r;
            a_col = rcol_r;
          end
          MODE_BLINK: begin
            ram_we    = 1'b1;
            ram_wdata = (blink_nxt < BLINK_SHOW) ? CH_CURSOR : CH_SPACE;
          end
          default: ram_we = 1'b0;
        endcase
      end
      ST_SCROLL: begin
        ram_we = 1'b1;
        a_col  = sweep_r;
      end
      ST_CURS: begin
        ram_we    = 1'b1;
        ram_wdata = CH_CURSOR;
      end
      default: ram_we = 1'b0;
    endcase
  end

  tts_ram #(.WIDTH(CHAR_W), .DEPTH(CELL_COUNT)) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      top_r       <= '0;
      blink_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (state_r == ST_EXEC) begin
        if (mode_r == MODE_PUT) begin
          cur_row_r <= row_nxt;
          cur_col_r <= col_nxt;
          if (put_scroll) begin
            top_r <= top_nxt;
          end
        end
        if (mode_r == MODE_BLINK) begin
          blink_r <= blink_nxt;
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_ch.mode;
      byte_r <= in_ch.data_byte[CHAR_W-1:0];
      rrow_r <= in_ch.read_row;
      rcol_r <= in_ch.read_col;
    end
    if (state_r == ST_EXEC) begin
      sweep_r  <= '0;
      scroll_r <= (mode_r == MODE_PUT) && put_scroll;
      cell_r   <= '0;
    end
    if (state_r == ST_SCROLL) begin
      sweep_r <= sweep_r + 1'b1;
    end
    if (state_r == ST_RDW) begin
      cell_r <= rd_ok ? ram_rdata : '0;
    end
    if (out_load) begin
      out_cell_r   <= cell_r;
      out_row_r    <= cur_row_r;
      out_col_r    <= cur_col_r;
      out_scroll_r <= scroll_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.cell_char  = out_cell_r;
  assign out_ch.cursor_row = out_row_r;
  assign out_ch.cursor_col = out_col_r;
  assign out_ch.scrolled   = out_scroll_r;

  a_cursor_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_row_r < ROW_W'(ROW_COUNT)) && (cur_col_r < COL_W'(COL_COUNT)))
    else $error("cursor outside the screen");

  a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    top_r < ROW_W'(ROW_COUNT))
    else $error("top row offset outside the ring");

  a_scroll_bottom: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCROLL) |-> (cur_row_r == ROW_W'(ROW_COUNT - 1)))
    else $error("scroll clear while cursor not on bottom row");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_EXEC) && !$past(state_r == ST_CLEAR))
    else $error("beat taken without starting work");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE || state_r == ST_RDW) |-> !ram_we)
    else $error("screen RAM written outside an update step");

endmodule
`default_nettype wire

>>> rtl/tts_ram.sv
`default_nettype none
module tts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire
